// ----- src/sparse_set_slot_map_defines.svh -----
// Assertion macros shared by the checker of the sparse set slot map.
// Each macro samples on the rising edge of clk and is off while arst_n is low.
`ifndef SPARSE_SET_SLOT_MAP_DEFINES_SVH
`define SPARSE_SET_SLOT_MAP_DEFINES_SVH

// Same-cycle implication.
`define SSM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SSM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/ssm_pkg.sv -----
package ssm_pkg;

	// Defaults for the top level parameters.
	localparam int SLOTS_DEF        = 64;
	localparam int PAYLOAD_BITS_DEF = 32;

	// Field widths of the request and response channels.
	localparam int CMD_W    = 3;
	localparam int HANDLE_W = 6;
	localparam int POS_W    = 6;
	localparam int DATA_W   = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 7;

	// Depth of the queue between the front and the back; a power of two.
	localparam int QUEUE_DEPTH = 2;

	// Command codes on the request channel.
	typedef enum logic [CMD_W-1:0] {
		CMD_ADD    = 3'd0,
		CMD_SET    = 3'd1,
		CMD_GET    = 3'd2,
		CMD_REMOVE = 3'd3,
		CMD_INDEX  = 3'd4
	} cmd_t;

	// Status codes on the response channel.
	typedef enum logic [STATUS_W-1:0] {
		ST_DONE   = 2'd0,
		ST_ABSENT = 2'd1,
		ST_FULL   = 2'd2
	} status_t;

	// Decoded operation kind.
	typedef enum logic [2:0] {
		OP_ADD,
		OP_SET,
		OP_GET,
		OP_REMOVE,
		OP_INDEX,
		OP_BAD
	} op_kind_t;

	// A classified command as it travels from the front to the back.
	typedef struct packed {
		op_kind_t              kind;
		logic                  h_ok;
		logic                  p_ok;
		logic [HANDLE_W-1:0]   handle;
		logic [POS_W-1:0]      pos;
		logic [DATA_W-1:0]     data;
	} op_t;

	// One response item.
	typedef struct packed {
		status_t               status;
		logic [HANDLE_W-1:0]   handle_out;
		logic [POS_W-1:0]      position_out;
		logic [DATA_W-1:0]     payload_out;
		logic [COUNT_W-1:0]    live_count;
	} rsp_t;

endpackage

// ----- src/ssm_req_if.sv -----
interface ssm_req_if import ssm_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [CMD_W-1:0]    command;
	logic [HANDLE_W-1:0] handle;
	logic [POS_W-1:0]    position_in;
	logic [DATA_W-1:0]   payload_in;

	modport source (output valid, command, handle, position_in, payload_in, input ready);
	modport sink (input valid, command, handle, position_in, payload_in, output ready);
endinterface

// ----- src/ssm_rsp_if.sv -----
interface ssm_rsp_if import ssm_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [HANDLE_W-1:0] handle_out;
	logic [POS_W-1:0]    position_out;
	logic [DATA_W-1:0]   payload_out;
	logic [COUNT_W-1:0]  live_count;

	modport source (output valid, status, handle_out, position_out, payload_out, live_count,
		input ready);
	modport sink (input valid, status, handle_out, position_out, payload_out, live_count,
		output ready);
endinterface

// ----- src/sparse_set_slot_map.sv -----
// Sparse set slot map: a table of stable handles whose entries are kept packed
// at dense positions, with swap-remove.
// The req channel carries a command (add, set, get, remove, index_of), a
// handle, a dense position and payload data; the rsp channel returns one item
// per request with status, handle, position, payload and the live count after
// the command. Both channels use valid and ready; a transfer happens at a
// rising edge with both high. Responses come back in request order.
// After a request leaves the queue, add, set, index_of and rejected commands
// pass through the read and evaluate steps, and get and remove of a present
// handle add a fetch step, since they must chain the registered reads of the
// maps and the valid bitmap twice. One command is executed at a time: the next
// one leaves the queue only once the last has finished.
// A two-entry queue lets requests transfer while the back end works, and a
// response register holds a finished result while the next command runs.
// When the receiver stalls, the final step of the next command waits and the
// queue fills, after which req.ready drops.
// Reset (arst_n low) empties the table and the queue; no clearing pass runs.
module sparse_set_slot_map import ssm_pkg::*; #(
	parameter int SLOTS        = SLOTS_DEF,
	parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	ssm_req_if.sink   req,
	ssm_rsp_if.source rsp
);
	logic q_full;
	logic push;
	logic head_valid;
	logic pop;
	op_t  push_op;
	op_t  head_op;

	// Front end: take requests and classify them.
	ssm_front #(.SLOTS(SLOTS)) u_front (
		.req     (req),
		.q_full  (q_full),
		.push    (push),
		.push_op (push_op)
	);

	// Queue between the front and the back.
	ssm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_op    (push_op),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_op    (head_op)
	);

	// Back end: carry the operations out on the maps.
	ssm_back #(.SLOTS(SLOTS), .PAYLOAD_BITS(PAYLOAD_BITS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (head_valid),
		.op       (head_op),
		.op_pop   (pop),
		.rsp      (rsp)
	);
endmodule

// ----- src/ssm_ram.sv -----
module ssm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one read port with registered read data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- src/ssm_front.sv -----
module ssm_front import ssm_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	ssm_req_if.sink req,
	input  logic    q_full,
	output logic    push,
	output op_t     push_op
);
	// A request transfers whenever the queue has room.
	assign req.ready = !q_full;
	assign push      = req.valid && !q_full;

	// Decode the command and flag handles and positions beyond the table.
	always_comb begin
		case (req.command)
			CMD_ADD:    push_op.kind = OP_ADD;
			CMD_SET:    push_op.kind = OP_SET;
			CMD_GET:    push_op.kind = OP_GET;
			CMD_REMOVE: push_op.kind = OP_REMOVE;
			CMD_INDEX:  push_op.kind = OP_INDEX;
			default:    push_op.kind = OP_BAD;
		endcase
		push_op.h_ok   = 32'(req.handle) < 32'(SLOTS);
		push_op.p_ok   = 32'(req.position_in) < 32'(SLOTS);
		push_op.handle = req.handle;
		push_op.pos    = req.position_in;
		push_op.data   = req.payload_in;
	end
endmodule

// ----- src/ssm_queue.sv -----
module ssm_queue import ssm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  push_op,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output op_t  head_op
);
	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int NW = $clog2(QUEUE_DEPTH + 1);

	op_t           entry_q [QUEUE_DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [NW-1:0] fill_q;

	assign full       = (fill_q == NW'(QUEUE_DEPTH));
	assign head_valid = (fill_q != '0);
	assign head_op    = entry_q[rd_ptr_q];

	// Pointers wrap naturally on a power-of-two depth; the fill level counts up to the depth.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			fill_q <= fill_q + NW'(push) - NW'(pop);
		end
	end

	// Entry storage needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end
endmodule

// ----- src/ssm_back.sv -----
module ssm_back import ssm_pkg::*; #(
	parameter int SLOTS        = SLOTS_DEF,
	parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     op_valid,
	input  op_t      op,
	output logic     op_pop,
	ssm_rsp_if.source rsp
);
	// Handle and count widths, and the layout of the valid bitmap in rows.
	localparam int HW   = $clog2(SLOTS);
	localparam int CW   = $clog2(SLOTS + 1);
	localparam int WB   = (SLOTS < 64) ? (1 << HW) : 64;
	localparam int LWB  = $clog2(WB);
	localparam int ROWS = (SLOTS + WB - 1) / WB;
	localparam int RBW  = (ROWS > 1) ? $clog2(ROWS) : 1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_EVAL,
		S_FETCH
	} state_t;

	state_t              state_q;
	op_t                 op_q;
	logic [CW-1:0]       count_q;
	logic [ROWS-1:0]     row_full_q;
	logic [ROWS-1:0]     row_seen_q;
	logic [RBW-1:0]      row_q;
	logic [HW-1:0]       hole_q;
	rsp_t                rsp_q;
	logic                rsp_valid_q;

	logic [HW-1:0]       hnd;
	logic [RBW-1:0]      hrow;
	logic [LWB-1:0]      hbit;
	logic [HW-1:0]       last;
	logic [RBW-1:0]      free_row;
	logic [RBW-1:0]      row_rd;
	logic [WB-1:0]       vword;
	logic [LWB-1:0]      zero_bit;
	logic [WB-1:0]       pad;
	logic [HW-1:0]       add_h;
	logic [LWB-1:0]      pbit;
	logic [HW-1:0]       ph;
	logic [WB-1:0]       place_word;
	logic [WB-1:0]       clr_word;
	logic                present;
	logic                full;
	logic [PAYLOAD_BITS-1:0] data_w;

	logic                do_place;
	logic                do_set_write;
	logic                do_remove;
	logic                do_move_pay;
	logic                final_step;
	logic                go_fetch;
	logic                adv;
	rsp_t                rsp_d;
	logic [CW-1:0]       count_d;

	logic                v_we;
	logic [WB-1:0]       v_wdata;
	logic [WB-1:0]       v_rdata;
	logic                sp_we;
	logic [HW-1:0]       sp_waddr;
	logic [HW-1:0]       sp_wdata;
	logic [HW-1:0]       sp_rdata;
	logic                ps_we;
	logic [HW-1:0]       ps_waddr;
	logic [HW-1:0]       ps_wdata;
	logic [HW-1:0]       ps_raddr;
	logic [HW-1:0]       ps_rdata;
	logic                pay_we;
	logic [HW-1:0]       pay_waddr;
	logic [PAYLOAD_BITS-1:0] pay_wdata;
	logic [HW-1:0]       pay_raddr;
	logic [PAYLOAD_BITS-1:0] pay_rdata;

	// Fields of the current operation.
	assign hnd    = HW'(op_q.handle);
	assign hrow   = RBW'(hnd >> LWB);
	assign hbit   = hnd[LWB-1:0];
	assign last   = HW'(count_q - CW'(1));
	assign data_w = PAYLOAD_BITS'(op_q.data);
	assign full   = (count_q == CW'(SLOTS));

	// Lowest row of the valid bitmap that still has a free handle.
	always_comb begin
		free_row = '0;
		for (int i = ROWS - 1; i >= 0; i--) begin
			if (!row_full_q[i]) begin
				free_row = RBW'(i);
			end
		end
	end

	assign row_rd = (op_q.kind == OP_ADD) ? free_row : hrow;

	// A row never written reads as all free.
	assign vword = row_seen_q[row_q] ? v_rdata : '0;

	// Lowest free bit in the row read, and bits that lie past the last handle.
	always_comb begin
		zero_bit = '0;
		for (int i = WB - 1; i >= 0; i--) begin
			if (!vword[i]) begin
				zero_bit = LWB'(i);
			end
		end
		for (int i = 0; i < WB; i++) begin
			pad[i] = 32'({row_q, LWB'(i)}) >= 32'(SLOTS);
		end
	end

	assign add_h      = HW'({row_q, zero_bit});
	assign present    = op_q.h_ok && vword[hbit];
	assign pbit       = (op_q.kind == OP_ADD) ? zero_bit : hbit;
	assign ph         = (op_q.kind == OP_ADD) ? add_h : hnd;
	assign place_word = vword | (WB'(1) << pbit);
	assign clr_word   = vword & ~(WB'(1) << hbit);

	// Decide the outcome of the operation at the evaluate and fetch steps.
	always_comb begin
		rsp_d.status       = ST_ABSENT;
		rsp_d.handle_out   = op_q.handle;
		rsp_d.position_out = '0;
		rsp_d.payload_out  = '0;
		rsp_d.live_count   = COUNT_W'(count_q);
		do_place           = 1'b0;
		do_set_write       = 1'b0;
		do_remove          = 1'b0;
		do_move_pay        = 1'b0;
		final_step         = 1'b0;
		go_fetch           = 1'b0;
		count_d            = count_q;
		case (state_q)
			S_EVAL: begin
				case (op_q.kind)
					OP_ADD: begin
						final_step       = 1'b1;
						rsp_d.handle_out = '0;
						if (full) begin
							rsp_d.status = ST_FULL;
						end else begin
							do_place           = 1'b1;
							count_d            = count_q + CW'(1);
							rsp_d.status       = ST_DONE;
							rsp_d.handle_out   = HANDLE_W'(add_h);
							rsp_d.position_out = POS_W'(count_q);
							rsp_d.payload_out  = DATA_W'(data_w);
							rsp_d.live_count   = COUNT_W'(count_d);
						end
					end
					OP_SET: begin
						final_step = 1'b1;
						if (!op_q.h_ok) begin
							rsp_d.status = ST_ABSENT;
						end else if (present) begin
							do_set_write       = 1'b1;
							rsp_d.status       = ST_DONE;
							rsp_d.position_out = POS_W'(sp_rdata);
						end else if (full) begin
							rsp_d.status = ST_FULL;
						end else begin
							do_place           = 1'b1;
							count_d            = count_q + CW'(1);
							rsp_d.status       = ST_DONE;
							rsp_d.position_out = POS_W'(count_q);
							rsp_d.live_count   = COUNT_W'(count_d);
						end
					end
					OP_GET: begin
						if (present) begin
							go_fetch = 1'b1;
						end else begin
							final_step = 1'b1;
						end
					end
					OP_REMOVE: begin
						if (present && (count_q != '0)) begin
							do_remove = 1'b1;
							go_fetch  = 1'b1;
						end else begin
							final_step = 1'b1;
						end
					end
					OP_INDEX: begin
						final_step         = 1'b1;
						rsp_d.position_out = op_q.pos;
						if (op_q.p_ok && (CW'(op_q.pos) < count_q)) begin
							rsp_d.status     = ST_DONE;
							rsp_d.handle_out = HANDLE_W'(ps_rdata);
						end
					end
					default: begin
						final_step         = 1'b1;
						rsp_d.position_out = op_q.pos;
					end
				endcase
			end
			S_FETCH: begin
				final_step         = 1'b1;
				rsp_d.status       = ST_DONE;
				rsp_d.position_out = POS_W'(hole_q);
				if (op_q.kind == OP_REMOVE) begin
					do_move_pay      = 1'b1;
					count_d          = count_q - CW'(1);
					rsp_d.live_count = COUNT_W'(count_d);
				end else begin
					rsp_d.payload_out = DATA_W'(pay_rdata);
				end
			end
			default: begin
			end
		endcase
	end

	// The last step of an operation waits for room in the output register.
	assign adv    = !final_step || !rsp_valid_q || rsp.ready;
	assign op_pop = (state_q == S_IDLE) && op_valid;

	// Valid bitmap port: set a bit on placement, clear it on removal.
	assign v_we    = adv && (do_place || do_remove);
	assign v_wdata = do_remove ? clr_word : place_word;

	// Both maps: append at the end, or move the last entry into the hole.
	assign sp_we    = adv && (do_place || do_remove);
	assign sp_waddr = do_remove ? ps_rdata : ph;
	assign sp_wdata = do_remove ? sp_rdata : HW'(count_q);
	assign ps_we    = sp_we;
	assign ps_waddr = do_remove ? sp_rdata : HW'(count_q);
	assign ps_wdata = do_remove ? ps_rdata : ph;
	assign ps_raddr = (op_q.kind == OP_REMOVE) ? last : HW'(op_q.pos);

	// Payload port: write on placement or set, and finish a removal's move.
	assign pay_we    = adv && (do_place || do_set_write || do_move_pay);
	assign pay_waddr = do_move_pay ? hole_q : (do_set_write ? sp_rdata : HW'(count_q));
	assign pay_wdata = do_move_pay ? pay_rdata : data_w;
	assign pay_raddr = (op_q.kind == OP_REMOVE) ? last :
		((state_q == S_FETCH) ? hole_q : sp_rdata);

	ssm_ram #(.WIDTH(WB), .DEPTH(ROWS)) u_valid (
		.clk   (clk),
		.we    (v_we),
		.waddr (row_q),
		.wdata (v_wdata),
		.raddr (row_rd),
		.rdata (v_rdata)
	);

	ssm_ram #(.WIDTH(HW), .DEPTH(SLOTS)) u_slot_pos (
		.clk   (clk),
		.we    (sp_we),
		.waddr (sp_waddr),
		.wdata (sp_wdata),
		.raddr (hnd),
		.rdata (sp_rdata)
	);

	ssm_ram #(.WIDTH(HW), .DEPTH(SLOTS)) u_pos_slot (
		.clk   (clk),
		.we    (ps_we),
		.waddr (ps_waddr),
		.wdata (ps_wdata),
		.raddr (ps_raddr),
		.rdata (ps_rdata)
	);

	ssm_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(SLOTS)) u_payload (
		.clk   (clk),
		.we    (pay_we),
		.waddr (pay_waddr),
		.wdata (pay_wdata),
		.raddr (pay_raddr),
		.rdata (pay_rdata)
	);

	// Sequencer, live count, row summaries and the output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			row_full_q  <= '0;
			row_seen_q  <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (final_step && adv) begin
				rsp_valid_q <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (op_valid) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (adv) begin
						state_q <= go_fetch ? S_FETCH : S_IDLE;
					end
				end
				S_FETCH: begin
					if (adv) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (adv) begin
				count_q <= count_d;
			end
			if (v_we) begin
				row_seen_q[row_q] <= 1'b1;
				row_full_q[row_q] <= &(v_wdata | pad);
			end
		end
	end

	// Operation, row, hole and response payload registers.
	always_ff @(posedge clk) begin
		if (op_pop) begin
			op_q <= op;
		end
		if (state_q == S_READ) begin
			row_q <= row_rd;
		end
		if (state_q == S_EVAL) begin
			hole_q <= sp_rdata;
		end
		if (final_step && adv) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = rsp_q.status;
	assign rsp.handle_out   = rsp_q.handle_out;
	assign rsp.position_out = rsp_q.position_out;
	assign rsp.payload_out  = rsp_q.payload_out;
	assign rsp.live_count   = rsp_q.live_count;
endmodule

// ----- src/ssm_checker.sv -----
`include "sparse_set_slot_map_defines.svh"

module ssm_checker import ssm_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input logic [STATUS_W-1:0] rsp_status,
	input logic [HANDLE_W-1:0] rsp_handle_out,
	input logic [POS_W-1:0]    rsp_position_out,
	input logic [DATA_W-1:0]   rsp_payload_out,
	input logic [COUNT_W-1:0]  rsp_live_count
);
	localparam int OW = $clog2(QUEUE_DEPTH + 3);

	logic [OW-1:0]      pending_q;
	logic [COUNT_W-1:0] last_q;
	logic               req_xfer;
	logic               rsp_xfer;

	assign req_xfer = req_valid && req_ready;
	assign rsp_xfer = rsp_valid && rsp_ready;

	// Requests in flight and the live count of the last response.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			last_q    <= '0;
		end else begin
			pending_q <= pending_q + OW'(req_xfer) - OW'(rsp_xfer);
			if (rsp_xfer) begin
				last_q <= rsp_live_count;
			end
		end
	end

	`SSM_ASSERT_IMP(a_rsp_has_req, rsp_valid, pending_q != '0,
		"response offered with no request outstanding")

	`SSM_ASSERT_IMP(a_count_step, rsp_valid,
		(rsp_live_count == last_q) || (rsp_live_count == last_q + COUNT_W'(1)) ||
		(last_q == rsp_live_count + COUNT_W'(1)),
		"live count moved by more than one between responses")

	`SSM_ASSERT_IMP(a_full_count, rsp_valid && (rsp_status == ST_FULL),
		rsp_live_count == COUNT_W'(SLOTS), "table full reported below capacity")

	`SSM_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready,
		rsp_valid && $stable(rsp_status) && $stable(rsp_handle_out) &&
		$stable(rsp_position_out) && $stable(rsp_payload_out) && $stable(rsp_live_count),
		"stalled response changed")
endmodule

bind sparse_set_slot_map ssm_checker #(.SLOTS(SLOTS)) u_ssm_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_status       (rsp.status),
	.rsp_handle_out   (rsp.handle_out),
	.rsp_position_out (rsp.position_out),
	.rsp_payload_out  (rsp.payload_out),
	.rsp_live_count   (rsp.live_count)
);
